/* design/bcz_pkg.sv */
// ----------------------------------------------------------------------------
// bcz_pkg: shared types and constants of the cubic Bezier point evaluator
// Sizes of control points, curve parameter, interpolation levels and
// register map.
// ----------------------------------------------------------------------------
`default_nettype none

package bcz_pkg;

	// field sizes
	localparam int COORD_BITS  = 12;
	localparam int T_FRAC_BITS = 10;
	localparam int T_W         = T_FRAC_BITS + 1;
	localparam int OFFSET_BITS = 10;
	localparam int OUT_BITS    = COORD_BITS + 1;

	// de Casteljau row: four points, three interpolation levels
	localparam int NPTS   = 4;
	localparam int LEVELS = NPTS - 1;
	localparam int FRAC3  = LEVELS * T_FRAC_BITS;
	// a level-3 value is the curve point scaled by 2^FRAC3
	localparam int LVL_W  = COORD_BITS + FRAC3;

	localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;

	// register map
	localparam int APB_AW = 3;
	localparam logic REG_X_OFFSET = 1'b0;
	localparam logic REG_Y_OFFSET = 1'b1;
	localparam logic [OFFSET_BITS-1:0] X_OFFSET_RST = OFFSET_BITS'(100);
	localparam logic [OFFSET_BITS-1:0] Y_OFFSET_RST = OFFSET_BITS'(700);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [OUT_BITS-1:0]   pix_t;
	typedef logic signed [LVL_W-1:0]      lvl_t;
	typedef lvl_t [NPTS-1:0]              row_t;

	// one item moving down the cell chain
	typedef struct packed {
		logic [T_W-1:0] t;
		row_t           x;
		row_t           y;
	} beat_t;

endpackage

`default_nettype wire

/* design/bcz_pt_if.sv */
// ----------------------------------------------------------------------------
// bcz_pt_if: control point channel
// Four control points and the curve parameter, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcz_pt_if;
	logic                     valid;
	logic                     ready;
	bcz_pkg::coord_t          ctrl_x0;
	bcz_pkg::coord_t          ctrl_y0;
	bcz_pkg::coord_t          ctrl_x1;
	bcz_pkg::coord_t          ctrl_y1;
	bcz_pkg::coord_t          ctrl_x2;
	bcz_pkg::coord_t          ctrl_y2;
	bcz_pkg::coord_t          ctrl_x3;
	bcz_pkg::coord_t          ctrl_y3;
	logic [bcz_pkg::T_W-1:0]  t_frac;

	modport source (
		output valid, ctrl_x0, ctrl_y0, ctrl_x1, ctrl_y1,
		ctrl_x2, ctrl_y2, ctrl_x3, ctrl_y3, t_frac,
		input  ready
	);
	modport sink (
		input  valid, ctrl_x0, ctrl_y0, ctrl_x1, ctrl_y1,
		ctrl_x2, ctrl_y2, ctrl_x3, ctrl_y3, t_frac,
		output ready
	);
endinterface

`default_nettype wire

/* design/bcz_px_if.sv */
// ----------------------------------------------------------------------------
// bcz_px_if: pixel channel
// One screen point per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcz_px_if;
	logic          valid;
	logic          ready;
	bcz_pkg::pix_t pixel_x;
	bcz_pkg::pix_t pixel_y;

	modport source (output valid, pixel_x, pixel_y, input ready);
	modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

`default_nettype wire

/* design/cubic_bezier_point_eval_core.sv */
// An accepted control point beat reaches its pixel beat through the three cell registers and the output register.
// Throughput: one point per cycle while no pixel beat stalls; a chain of three interpolation cells
// and one placement stage, each a single register step.
// The whole chain holds while a pixel beat waits on ready.
// Reset (arst_n low): pipeline emptied, x_offset = 100, y_offset = 700.
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval_core: cubic Bezier point evaluator
// De Casteljau evaluation of both coordinates through a row of blend
// cells, exact fixed point, then truncation and screen placement.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_point_eval_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	bcz_pt_if.sink                            ctrl,
	bcz_px_if.source                          pixel,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [bcz_pkg::APB_AW-1:0]   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready
);

	logic [bcz_pkg::OFFSET_BITS-1:0] x_offset_q, y_offset_q;
	logic                            ce;
	logic                            reg_sel;
	logic [bcz_pkg::T_W-1:0]         t_sat;
	bcz_pkg::beat_t                  cell_d [bcz_pkg::LEVELS+1];
	logic                            cell_v [bcz_pkg::LEVELS+1];

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q <= bcz_pkg::X_OFFSET_RST;
			y_offset_q <= bcz_pkg::Y_OFFSET_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				bcz_pkg::REG_X_OFFSET: x_offset_q <= pwdata[bcz_pkg::OFFSET_BITS-1:0];
				bcz_pkg::REG_Y_OFFSET: y_offset_q <= pwdata[bcz_pkg::OFFSET_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			bcz_pkg::REG_X_OFFSET: prdata = 32'(x_offset_q);
			bcz_pkg::REG_Y_OFFSET: prdata = 32'(y_offset_q);
			default:               prdata = '0;
		endcase
	end

	// chain advances unless a finished pixel is stalled
	assign ce         = !pixel.valid || pixel.ready;
	assign ctrl.ready = ce;

	// input row: saturate t at one, widen points to lane width
	assign t_sat = (ctrl.t_frac > bcz_pkg::T_ONE) ? bcz_pkg::T_ONE : ctrl.t_frac;

	always_comb begin
		cell_d[0].t    = t_sat;
		cell_d[0].x[0] = bcz_pkg::LVL_W'(ctrl.ctrl_x0);
		cell_d[0].x[1] = bcz_pkg::LVL_W'(ctrl.ctrl_x1);
		cell_d[0].x[2] = bcz_pkg::LVL_W'(ctrl.ctrl_x2);
		cell_d[0].x[3] = bcz_pkg::LVL_W'(ctrl.ctrl_x3);
		cell_d[0].y[0] = bcz_pkg::LVL_W'(ctrl.ctrl_y0);
		cell_d[0].y[1] = bcz_pkg::LVL_W'(ctrl.ctrl_y1);
		cell_d[0].y[2] = bcz_pkg::LVL_W'(ctrl.ctrl_y2);
		cell_d[0].y[3] = bcz_pkg::LVL_W'(ctrl.ctrl_y3);
		cell_v[0]      = ctrl.valid;
	end

	// row of blend cells, one de Casteljau level each
	for (genvar i = 0; i < bcz_pkg::LEVELS; i++) begin : g_cell
		bcz_lerp_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (ce),
			.in_v  (cell_v[i]),
			.d     (cell_d[i]),
			.out_v (cell_v[i+1]),
			.q     (cell_d[i+1])
		);
	end

	// truncation and placement, output register
	bcz_place u_place (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (ce),
		.in_v    (cell_v[bcz_pkg::LEVELS]),
		.d       (cell_d[bcz_pkg::LEVELS]),
		.x_offset(x_offset_q),
		.y_offset(y_offset_q),
		.out_v   (pixel.valid),
		.pixel_x (pixel.pixel_x),
		.pixel_y (pixel.pixel_y)
	);

endmodule

`default_nettype wire

/* design/bcz_lerp_cell.sv */
// ----------------------------------------------------------------------------
// bcz_lerp_cell: one de Casteljau level
// Blends each pair of neighboring points, a*(1-t) + b*t, as
// a*2^T_FRAC_BITS + t*(b-a), keeping every fraction bit. The row shrinks
// by one point per cell; the top lane is cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bcz_lerp_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_v,
	input  wire bcz_pkg::beat_t d,
	output logic                out_v,
	output bcz_pkg::beat_t      q
);

	bcz_pkg::beat_t                 nxt;
	logic signed [bcz_pkg::T_W:0]   ts;
	logic                           v_q;
	bcz_pkg::beat_t                 beat_q;

	// blend neighbors; lane width is enough for the final level, so
	// intermediate wrap cancels out
	always_comb begin
		nxt = d;
		ts  = $signed({1'b0, d.t});
		for (int k = 0; k < bcz_pkg::NPTS - 1; k++) begin
			nxt.x[k] = ($signed(d.x[k]) <<< bcz_pkg::T_FRAC_BITS)
				+ ($signed(d.x[k+1]) - $signed(d.x[k])) * ts;
			nxt.y[k] = ($signed(d.y[k]) <<< bcz_pkg::T_FRAC_BITS)
				+ ($signed(d.y[k+1]) - $signed(d.y[k])) * ts;
		end
		nxt.x[bcz_pkg::NPTS-1] = '0;
		nxt.y[bcz_pkg::NPTS-1] = '0;
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			beat_q <= nxt;
		end
	end

	assign out_v = v_q;
	assign q     = beat_q;

endmodule

`default_nettype wire

/* design/bcz_place.sv */
// ----------------------------------------------------------------------------
// bcz_place: final truncation and screen placement
// Truncates the level-3 point toward zero and places it: x plus x_offset,
// y_offset minus y. Holds the result beat until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bcz_place (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire logic                                in_v,
	input  wire bcz_pkg::beat_t                      d,
	input  wire logic [bcz_pkg::OFFSET_BITS-1:0]     x_offset,
	input  wire logic [bcz_pkg::OFFSET_BITS-1:0]     y_offset,
	output logic                                     out_v,
	output bcz_pkg::pix_t                            pixel_x,
	output bcz_pkg::pix_t                            pixel_y
);

	bcz_pkg::coord_t tx, ty;
	logic            v_q;
	bcz_pkg::pix_t   px_q, py_q;

	// floor part, plus one when negative with a nonzero fraction
	function automatic bcz_pkg::coord_t trunc0(input bcz_pkg::lvl_t v);
		logic inc;
		inc = v[bcz_pkg::LVL_W-1] && (|v[bcz_pkg::FRAC3-1:0]);
		return $signed(v[bcz_pkg::LVL_W-1 -: bcz_pkg::COORD_BITS])
			+ bcz_pkg::COORD_BITS'(inc);
	endfunction

	always_comb begin
		tx = trunc0(d.x[0]);
		ty = trunc0(d.y[0]);
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (en) begin
			px_q <= bcz_pkg::OUT_BITS'(x_offset) + bcz_pkg::OUT_BITS'(tx);
			py_q <= bcz_pkg::OUT_BITS'(y_offset) - bcz_pkg::OUT_BITS'(ty);
		end
	end

	assign out_v   = v_q;
	assign pixel_x = px_q;
	assign pixel_y = py_q;

endmodule

`default_nettype wire

/* design/bcz_chk.sv */
// ----------------------------------------------------------------------------
// bcz_chk: port checks for the Bezier point evaluator
// Watches the two channels at the top level and flags handshake and
// flow-control slips.
// ----------------------------------------------------------------------------
`default_nettype none

module bcz_chk (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire bcz_pkg::pix_t pixel_x,
	input wire bcz_pkg::pix_t pixel_y
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// a stalled pixel beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pixel beat dropped while stalled");

	// and keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pixel_x) && $stable(pixel_y))
		else $error("pixel payload changed while stalled");

	// input side is open exactly when the output register can move
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output flow");

	// with no stall, a beat that goes in comes out through the three cell registers and the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, 4) && $past(arst_n, 3) && $past(arst_n, 2) && $past(arst_n, 1)
		&& $past(in_acc, 4) && $past(in_ready, 3) && $past(in_ready, 2)
		&& $past(in_ready, 1) |-> out_valid)
		else $error("pixel beat missing after pipeline latency");

endmodule

bind cubic_bezier_point_eval_core bcz_chk u_bcz_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (ctrl.valid),
	.in_ready (ctrl.ready),
	.out_valid(pixel.valid),
	.out_ready(pixel.ready),
	.pixel_x  (pixel.pixel_x),
	.pixel_y  (pixel.pixel_y)
);

`default_nettype wire
